// ===== rtl/otsu_pkg.sv =====
`default_nettype none
package otsu_pkg;

    localparam int CNT_W      = 24;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam int BINS       = 256;
    localparam int ADDR_W     = 8;
    // sum of all bins and sum of value * count
    localparam int WALL_W     = 32;
    localparam int SALL_W     = 40;
    // |N*Sl - Wl*S|, its square, and Wl*Wh
    localparam int D_W        = 72;
    localparam int NUM_W      = 144;
    localparam int DEN_W      = 64;
    // shared shift-add multiplier
    localparam int MX_W       = 144;
    localparam int MY_W       = 72;
    localparam int MP_W       = 216;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [ADDR_W-1:0] T_FIRST = 8'd1;
    localparam logic [ADDR_W-1:0] T_LAST  = 8'd254;

    typedef struct packed {
        logic [ADDR_W-1:0] gray;
        logic              last;
    } t_pix;

    typedef struct packed {
        logic              req;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic              img_end;
        logic              sat;
        logic [CNT_W-1:0]  n;
        logic [WALL_W-1:0] wall;
        logic [SALL_W-1:0] sall;
    } t_hist_stat;

endpackage
`default_nettype wire

// ===== rtl/otsu_ram.sv =====
`default_nettype none
module otsu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/otsu_fifo.sv =====
`default_nettype none
module otsu_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire otsu_pkg::t_pix i_data,
    input  wire logic          i_pop,
    output otsu_pkg::t_pix     o_data,
    output logic               o_empty,
    output logic               o_full
);

    otsu_pkg::t_pix                  r_mem [otsu_pkg::FIFO_DEPTH];
    logic [otsu_pkg::FIFO_AW-1:0]    r_wp;
    logic [otsu_pkg::FIFO_AW-1:0]    r_rp;
    logic [otsu_pkg::FIFO_AW:0]      r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + otsu_pkg::FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + otsu_pkg::FIFO_AW'(1);
            end
            r_cnt <= r_cnt + (otsu_pkg::FIFO_AW+1)'(i_push) - (otsu_pkg::FIFO_AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (otsu_pkg::FIFO_AW+1)'(otsu_pkg::FIFO_DEPTH));

endmodule
`default_nettype wire

// ===== rtl/otsu_hist.sv =====
`default_nettype none
module otsu_hist (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_pix_valid,
    input  wire otsu_pkg::t_pix              i_pix,
    input  wire otsu_pkg::t_rd_req           i_rd,
    output logic [otsu_pkg::CNT_W-1:0]       o_rd_data,
    input  wire logic                        i_clear,
    output otsu_pkg::t_hist_stat             o_stat
);

    logic [otsu_pkg::BINS-1:0]     r_vld;
    logic                          r_s1_v;
    logic                          r_s1_last;
    logic [otsu_pkg::ADDR_W-1:0]   r_s1_g;
    logic                          r_lw_v;
    logic [otsu_pkg::ADDR_W-1:0]   r_lw_a;
    logic [otsu_pkg::CNT_W-1:0]    r_lw_d;
    logic [otsu_pkg::CNT_W-1:0]    r_n;
    logic                          r_sat;
    logic [otsu_pkg::WALL_W-1:0]   r_wall;
    logic [otsu_pkg::SALL_W-1:0]   r_sall;

    logic [otsu_pkg::CNT_W-1:0]    ram_rdata;
    logic [otsu_pkg::ADDR_W-1:0]   raddr;
    logic [otsu_pkg::CNT_W-1:0]    cur;
    logic [otsu_pkg::CNT_W-1:0]    upd;
    logic                          bin_sat;
    logic                          tot_sat;

    assign raddr = i_pix_valid ? i_pix.gray : i_rd.addr;

    // RAM read of a pixel is issued before the write ahead of it lands: bypass the newest write
    always_comb begin
        if (r_lw_v && (r_lw_a == r_s1_g)) begin
            cur = r_lw_d;
        end else if (r_vld[r_s1_g]) begin
            cur = ram_rdata;
        end else begin
            cur = '0;
        end
    end

    assign bin_sat = (cur == otsu_pkg::CNT_MAX);
    assign tot_sat = (r_n == otsu_pkg::CNT_MAX);
    assign upd     = bin_sat ? cur : cur + otsu_pkg::CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_vld  <= '0;
            r_s1_v <= 1'b0;
            r_lw_v <= 1'b0;
            r_n    <= '0;
            r_sat  <= 1'b0;
            r_wall <= '0;
            r_sall <= '0;
        end else begin
            r_s1_v <= i_pix_valid;
            if (r_s1_v) begin
                r_vld[r_s1_g] <= 1'b1;
                r_lw_v        <= 1'b1;
                if (!bin_sat) begin
                    r_wall <= r_wall + otsu_pkg::WALL_W'(1);
                    r_sall <= r_sall + otsu_pkg::SALL_W'(r_s1_g);
                end
                if (!tot_sat) begin
                    r_n <= r_n + otsu_pkg::CNT_W'(1);
                end
                if (bin_sat || tot_sat) begin
                    r_sat <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix_valid || i_rd.req) begin
            r_s1_g    <= raddr;
        end
        r_s1_last <= i_pix.last;
        if (r_s1_v) begin
            r_lw_a <= r_s1_g;
            r_lw_d <= upd;
        end
    end

    otsu_ram #(
        .WIDTH (otsu_pkg::CNT_W),
        .DEPTH (otsu_pkg::BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_v),
        .i_waddr (r_s1_g),
        .i_wdata (upd),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    assign o_rd_data      = cur;
    assign o_stat.img_end = r_s1_v && r_s1_last;
    assign o_stat.sat     = r_sat;
    assign o_stat.n       = r_n;
    assign o_stat.wall    = r_wall;
    assign o_stat.sall    = r_sall;

endmodule
`default_nettype wire

// ===== rtl/otsu_mul.sv =====
`default_nettype none
module otsu_mul (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [otsu_pkg::MX_W-1:0] i_x,
    input  wire logic [otsu_pkg::MY_W-1:0] i_y,
    output logic                           o_done,
    output logic [otsu_pkg::MP_W-1:0]      o_prod
);

    logic                          r_busy;
    logic                          r_done;
    logic [otsu_pkg::MP_W-1:0]     r_x;
    logic [otsu_pkg::MY_W-1:0]     r_y;
    logic [otsu_pkg::MP_W-1:0]     r_acc;

    // shift-add, one multiplier bit per beat; stops once the rest is zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_y == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= otsu_pkg::MP_W'(i_x);
            r_y   <= i_y;
            r_acc <= '0;
        end else if (r_busy && (r_y != '0)) begin
            if (r_y[0]) begin
                r_acc <= r_acc + r_x;
            end
            r_x <= r_x << 1;
            r_y <= r_y >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule
`default_nettype wire

// ===== rtl/otsu_search.sv =====
`default_nettype none
module otsu_search (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire otsu_pkg::t_hist_stat        i_stat,
    input  wire logic [otsu_pkg::CNT_W-1:0]  i_bin,
    output otsu_pkg::t_rd_req                o_rd,
    output logic                             o_valid,
    output logic [otsu_pkg::ADDR_W-1:0]      o_threshold,
    output logic                             o_count_overflow
);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_ACC, S_CHK, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6
    } t_state;

    t_state                          r_state;
    logic [otsu_pkg::ADDR_W-1:0]     r_t;
    logic [otsu_pkg::WALL_W-1:0]     r_wl;
    logic [otsu_pkg::SALL_W-1:0]     r_sl;
    logic [otsu_pkg::D_W-1:0]        r_a;
    logic [otsu_pkg::NUM_W-1:0]      r_num;
    logic [otsu_pkg::DEN_W-1:0]      r_den;
    logic [otsu_pkg::MP_W-1:0]       r_lhs;
    logic [otsu_pkg::NUM_W-1:0]      r_best_num;
    logic [otsu_pkg::DEN_W-1:0]      r_best_den;
    logic [otsu_pkg::ADDR_W-1:0]     r_best_t;
    logic                            r_valid;
    logic [otsu_pkg::ADDR_W-1:0]     r_thr;
    logic                            r_ovf;

    logic                            mul_start;
    logic [otsu_pkg::MX_W-1:0]       mul_x;
    logic [otsu_pkg::MY_W-1:0]       mul_y;
    logic                            mul_done;
    logic [otsu_pkg::MP_W-1:0]       mul_p;
    logic [otsu_pkg::WALL_W-1:0]     wh;
    logic [otsu_pkg::D_W-1:0]        b;
    logic [otsu_pkg::D_W-1:0]        d;
    logic                            win;
    logic                            skip;
    logic [otsu_pkg::ADDR_W-1:0]     fin_thr;

    assign wh   = i_stat.wall - r_wl;
    assign skip = (r_wl == '0) || (wh == '0);
    assign b    = mul_p[otsu_pkg::D_W-1:0];
    assign d    = (r_a >= b) ? (r_a - b) : (b - r_a);
    assign win  = (r_lhs > mul_p);
    assign fin_thr = (r_state == S_M6 && win) ? r_t : r_best_t;

    always_comb begin
        mul_start = 1'b0;
        mul_x     = '0;
        mul_y     = '0;
        case (r_state)
            S_CHK: begin
                mul_start = !skip;
                mul_x     = otsu_pkg::MX_W'(r_sl);
                mul_y     = otsu_pkg::MY_W'(i_stat.n);
            end
            S_M1: begin
                mul_start = mul_done;
                mul_x     = otsu_pkg::MX_W'(i_stat.sall);
                mul_y     = otsu_pkg::MY_W'(r_wl);
            end
            S_M2: begin
                mul_start = mul_done;
                mul_x     = otsu_pkg::MX_W'(d);
                mul_y     = d;
            end
            S_M3: begin
                mul_start = mul_done;
                mul_x     = otsu_pkg::MX_W'(r_wl);
                mul_y     = otsu_pkg::MY_W'(wh);
            end
            S_M4: begin
                mul_start = mul_done;
                mul_x     = r_num;
                mul_y     = otsu_pkg::MY_W'(r_best_den);
            end
            S_M5: begin
                mul_start = mul_done;
                mul_x     = r_best_num;
                mul_y     = otsu_pkg::MY_W'(r_den);
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    assign o_rd.req  = (r_state == S_RD);
    assign o_rd.addr = r_t - otsu_pkg::ADDR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_t        <= otsu_pkg::T_FIRST;
                    r_wl       <= '0;
                    r_sl       <= '0;
                    r_best_num <= '0;
                    r_best_den <= otsu_pkg::DEN_W'(1);
                    r_best_t   <= otsu_pkg::T_FIRST;
                    if (i_stat.img_end) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_wl    <= r_wl + otsu_pkg::WALL_W'(i_bin);
                    r_sl    <= r_sl + otsu_pkg::SALL_W'(i_bin)
                                    * otsu_pkg::SALL_W'(o_rd.addr);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (skip) begin
                        if (r_t == otsu_pkg::T_LAST) begin
                            r_valid <= 1'b1;
                            r_thr   <= fin_thr;
                            r_ovf   <= i_stat.sat;
                            r_state <= S_IDLE;
                        end else begin
                            r_t     <= r_t + otsu_pkg::ADDR_W'(1);
                            r_state <= S_RD;
                        end
                    end else begin
                        r_state <= S_M1;
                    end
                end
                S_M1: begin
                    if (mul_done) begin
                        r_a     <= mul_p[otsu_pkg::D_W-1:0];
                        r_state <= S_M2;
                    end
                end
                S_M2: begin
                    if (mul_done) begin
                        r_state <= S_M3;
                    end
                end
                S_M3: begin
                    if (mul_done) begin
                        r_num   <= mul_p[otsu_pkg::NUM_W-1:0];
                        r_state <= S_M4;
                    end
                end
                S_M4: begin
                    if (mul_done) begin
                        r_den   <= mul_p[otsu_pkg::DEN_W-1:0];
                        r_state <= S_M5;
                    end
                end
                S_M5: begin
                    if (mul_done) begin
                        r_lhs   <= mul_p;
                        r_state <= S_M6;
                    end
                end
                S_M6: begin
                    if (mul_done) begin
                        if (win) begin
                            r_best_num <= r_num;
                            r_best_den <= r_den;
                            r_best_t   <= r_t;
                        end
                        if (r_t == otsu_pkg::T_LAST) begin
                            r_valid <= 1'b1;
                            r_thr   <= fin_thr;
                            r_ovf   <= i_stat.sat;
                            r_state <= S_IDLE;
                        end else begin
                            r_t     <= r_t + otsu_pkg::ADDR_W'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    otsu_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_x     (mul_x),
        .i_y     (mul_y),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    assign o_valid          = r_valid;
    assign o_threshold      = r_thr;
    assign o_count_overflow = r_ovf;

endmodule
`default_nettype wire

// ===== rtl/otsu_threshold_from_histogram.sv =====
`default_nettype none
// Otsu threshold of one 8-bit gray image. Pulse start with a pixel whenever
// busy is low; while the image streams in, one beat is taken every cycle.
// Pixels go through a four-entry queue into the histogram updater, a
// read-modify-write pipeline on a 256 x 24-bit RAM with a bypass of the
// newest write, so a run of equal gray values counts correctly. Once the
// beat with i_last_pixel is taken, busy stays high until the result: the
// search walks thresholds 1..254, one bin read per threshold, and for every
// threshold with both classes non-empty runs six products through one
// shift-add multiplier that stops once the rest of the second operand is zero
// (second operands: N, Wl, the 72-bit difference, Wh, and two 64-bit class
// products). The result shows on o_threshold / o_count_overflow for exactly
// one cycle with o_valid high; the receiver cannot stall it. In that same
// cycle the histogram is cleared and busy drops on the next cycle.
// Bins and the pixel count saturate at 2^24-1; o_count_overflow reports it.
module otsu_threshold_from_histogram (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  i_gray_sample,
    input  wire logic        i_last_pixel,
    output logic             o_valid,
    output logic [7:0]       o_threshold,
    output logic             o_count_overflow
);

    logic                            r_img_done;   // last pixel taken, result pending
    logic                            push;
    logic                            fifo_empty;
    logic                            fifo_full;
    otsu_pkg::t_pix                  pix_in;
    otsu_pkg::t_pix                  pix_q;
    otsu_pkg::t_rd_req               rd;
    otsu_pkg::t_hist_stat            stat;
    logic [otsu_pkg::CNT_W-1:0]      bin;

    assign busy        = fifo_full || r_img_done;
    assign push        = start && !busy;
    assign pix_in.gray = i_gray_sample;
    assign pix_in.last = i_last_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_done <= 1'b0;
        end else if (push && i_last_pixel) begin
            r_img_done <= 1'b1;
        end else if (o_valid) begin
            r_img_done <= 1'b0;
        end
    end

    // front: beat queue
    otsu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (pix_in),
        .i_pop   (!fifo_empty),
        .o_data  (pix_q),
        .o_empty (fifo_empty),
        .o_full  (fifo_full)
    );

    // back: histogram and totals
    otsu_hist u_hist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (!fifo_empty),
        .i_pix       (pix_q),
        .i_rd        (rd),
        .o_rd_data   (bin),
        .i_clear     (o_valid),
        .o_stat      (stat)
    );

    // back: threshold search
    otsu_search u_search (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_stat           (stat),
        .i_bin            (bin),
        .o_rd             (rd),
        .o_valid          (o_valid),
        .o_threshold      (o_threshold),
        .o_count_overflow (o_count_overflow)
    );

    a_valid_needs_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_img_done)
        else $error("result without a finished image");

    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && i_last_pixel) |=> busy)
        else $error("beat taken after last pixel");

    a_thr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_threshold != 8'd0 && o_threshold != 8'd255))
        else $error("threshold out of range");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

endmodule
`default_nettype wire
